/* sv/skf_pkg.sv */
package skf_pkg;

    // Variance and noise format: unsigned Q8.24
    localparam int VAR_W     = 32;
    localparam int FRAC_BITS = 24;

    // Gain is unsigned Q1.24 in 0..1, so it needs one bit above the fraction to hold one
    localparam int K_W       = FRAC_BITS + 1;

    // Dividend of the gain divide: pm << 24 plus half the denominator
    localparam int NUM_W     = VAR_W + K_W;
    localparam int DEN_W     = VAR_W + 1;

    // Shared multiplier: one 32-bit chunk by the 25-bit gain
    localparam int CHUNK_W   = 32;
    localparam int PROD_W    = CHUNK_W + K_W;

    localparam logic [K_W-1:0]   ONE_Q24  = K_W'(1) << FRAC_BITS;
    localparam logic [VAR_W-1:0] HALF_Q24 = VAR_W'(1) << (FRAC_BITS - 1);
    localparam logic [VAR_W-1:0] VAR_MAX  = '1;

    localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = 32'd8389;
    localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 32'd1677722;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

endpackage

/* sv/scalar_kalman_smoother_top.sv */
// Scalar Kalman filter, one sample per item, worked on a shared divide/multiply sequencer.
// A new sample is taken only once the previous one is finished: the 25-step gain divide and
// the shared 32x25 multiplier passes run in turn, and in_stall stays high while busy.
// Reset (rst_n, async, active low): estimate and variance clear to zero, Q and R take their
// default values, no result is pending.
module scalar_kalman_smoother_top #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [skf_pkg::VAR_W-1:0]             cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        estimate
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int NCHUNK = (SW + skf_pkg::CHUNK_W - 1) / skf_pkg::CHUNK_W;
    localparam int MW     = NCHUNK * skf_pkg::CHUNK_W;
    localparam int AW     = MW + skf_pkg::K_W;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int VW     = skf_pkg::VAR_W;
    localparam int KW     = skf_pkg::K_W;
    localparam int FB     = skf_pkg::FRAC_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_LOAD = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_MULV = 4'd4;
    localparam logic [3:0] ST_MULM = 4'd5;
    localparam logic [3:0] ST_ACC  = 4'd6;
    localparam logic [3:0] ST_RND  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_GAIN = 4'd9;

    localparam logic [4:0]    DIV_LAST  = 5'(KW - 1);
    localparam logic [CW-1:0] CHUNK_TOP = CW'(NCHUNK - 1);

    logic [3:0]                   state_reg, state_next;
    logic [VW-1:0]                q_reg, q_next;
    logic [VW-1:0]                r_reg, r_next;
    logic signed [SW-1:0]         x_reg, x_next;
    logic [VW-1:0]                p_reg, p_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [SW-1:0]         estimate_reg, estimate_next;

    logic signed [SW-1:0]         z_reg, z_next;
    logic [VW-1:0]                pm_reg, pm_next;
    logic [skf_pkg::DEN_W-1:0]    den_reg, den_next;
    logic [skf_pkg::DEN_W-1:0]    rem_reg, rem_next;
    logic [KW-1:0]                quot_reg, quot_next;
    logic [4:0]                   div_cnt_reg, div_cnt_next;
    logic [KW-1:0]                k_reg, k_next;
    logic                         up_reg, up_next;
    logic [MW-1:0]                mag_reg, mag_next;
    logic [CW-1:0]                chunk_cnt_reg, chunk_cnt_next;
    logic [skf_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [AW-1:0]                acc_reg, acc_next;
    logic [SW-1:0]                step_reg, step_next;
    logic [VW-1:0]                var_new_reg, var_new_next;

    logic                         in_fire;
    logic                         out_free;
    logic [VW:0]                  pq_sum;
    logic [skf_pkg::NUM_W-1:0]    num;
    logic signed [SW:0]           diff;
    logic [SW:0]                  diff_neg;
    logic [skf_pkg::DEN_W:0]      trial;
    logic                         trial_ge;
    logic [skf_pkg::CHUNK_W-1:0]  mul_a;
    logic [KW-1:0]                mul_b;
    logic [skf_pkg::PROD_W-1:0]   mul_p;
    logic [skf_pkg::PROD_W:0]     var_round;
    logic [AW-1:0]                acc_shift;
    logic [AW-1:0]                acc_round;
    logic signed [SW-1:0]         x_new;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;

    assign pq_sum   = {1'b0, p_reg} + {1'b0, q_reg};
    assign num      = {pm_reg, {FB{1'b0}}} + skf_pkg::NUM_W'(den_reg >> 1);
    assign diff     = {z_reg[SW-1], z_reg} - {x_reg[SW-1], x_reg};
    assign diff_neg = (SW + 1)'(-diff);

    assign trial    = {rem_reg, quot_reg[KW-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    // One shared multiplier: variance term first, then the magnitude chunks
    assign mul_a = (state_reg == ST_MULV) ? pm_reg
                 : mag_reg[int'(chunk_cnt_reg) * skf_pkg::CHUNK_W +: skf_pkg::CHUNK_W];
    assign mul_b = (state_reg == ST_MULV) ? (skf_pkg::ONE_Q24 - k_reg) : k_reg;
    assign mul_p = skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);

    assign var_round = {1'b0, prod_reg} + (skf_pkg::PROD_W + 1)'(skf_pkg::HALF_Q24);
    assign acc_shift = {acc_reg[AW-skf_pkg::CHUNK_W-1:0], {skf_pkg::CHUNK_W{1'b0}}}
                     + AW'(prod_reg);
    assign acc_round = acc_reg + AW'(skf_pkg::HALF_Q24);
    assign x_new     = up_reg ? (x_reg + $signed(step_reg)) : (x_reg - $signed(step_reg));

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg;
        estimate_next  = estimate_reg;
        z_next         = z_reg;
        pm_next        = pm_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        div_cnt_next   = div_cnt_reg;
        k_next         = k_reg;
        up_next        = up_reg;
        mag_next       = mag_reg;
        chunk_cnt_next = chunk_cnt_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        var_new_next   = var_new_reg;

        if (cfg_we)
        begin
            if (cfg_index == skf_pkg::REG_PROCESS_NOISE)
            begin
                q_next = cfg_data;
            end
            if (cfg_index == skf_pkg::REG_MEASUREMENT_NOISE)
            begin
                r_next = cfg_data;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    z_next     = sample;
                    pm_next    = pq_sum[VW] ? skf_pkg::VAR_MAX : pq_sum[VW-1:0];
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                den_next   = {1'b0, pm_reg} + {1'b0, r_reg};
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rem_next     = skf_pkg::DEN_W'(num[skf_pkg::NUM_W-1:KW]);
                quot_next    = num[KW-1:0];
                div_cnt_next = DIV_LAST;
                up_next      = !diff[SW];
                mag_next     = MW'(diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0]);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // Restoring divide, one quotient bit per cycle
                rem_next  = trial_ge ? skf_pkg::DEN_W'(trial - {1'b0, den_reg})
                                     : skf_pkg::DEN_W'(trial);
                quot_next = {quot_reg[KW-2:0], trial_ge};
                if (div_cnt_reg == 5'd0)
                begin
                    state_next = ST_GAIN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 5'd1;
                end
            end
            ST_GAIN:
            begin
                // Zero denominator means zero gain
                if (den_reg == '0)
                begin
                    k_next = '0;
                end
                else if (quot_reg > skf_pkg::ONE_Q24)
                begin
                    k_next = skf_pkg::ONE_Q24;
                end
                else
                begin
                    k_next = quot_reg;
                end
                state_next = ST_MULV;
            end
            ST_MULV:
            begin
                // Issue the variance product, then start the magnitude chunks from the top
                prod_next      = mul_p;
                chunk_cnt_next = CHUNK_TOP;
                state_next     = ST_MULM;
            end
            ST_MULM:
            begin
                prod_next = mul_p;
                if (chunk_cnt_reg == CHUNK_TOP)
                begin
                    // Previous product is the variance term
                    var_new_next = var_round[FB +: VW];
                    acc_next     = '0;
                end
                else
                begin
                    acc_next = acc_shift;
                end
                if (chunk_cnt_reg == '0)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    chunk_cnt_next = chunk_cnt_reg - CW'(1);
                end
            end
            ST_ACC:
            begin
                acc_next   = acc_shift;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                step_next  = acc_round[FB +: SW];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    estimate_next  = x_new;
                    out_valid_next = 1'b1;
                    x_next         = x_new;
                    p_next         = var_new_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_reg         <= skf_pkg::PROCESS_NOISE_RST;
            r_reg         <= skf_pkg::MEASUREMENT_NOISE_RST;
            x_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            x_reg         <= x_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        estimate_reg  <= estimate_next;
        z_reg         <= z_next;
        pm_reg        <= pm_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        div_cnt_reg   <= div_cnt_next;
        k_reg         <= k_next;
        up_reg        <= up_next;
        mag_reg       <= mag_next;
        chunk_cnt_reg <= chunk_cnt_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        step_reg      <= step_next;
        var_new_reg   <= var_new_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_PREP))
        else $error("accepted item did not start the sequencer");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg == 5'd0) |=> (state_reg == ST_GAIN))
        else $error("gain divide did not end after its last step");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULM) |-> (k_reg <= skf_pkg::ONE_Q24))
        else $error("gain above one");

    a_var_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (var_new_reg <= pm_reg))
        else $error("updated variance above predicted variance");

    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (out_valid_reg && estimate_reg == x_reg))
        else $error("delivered estimate differs from stored estimate");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

class estimate_tracker;
    logic [31:0]        process_noise;
    logic [31:0]        measurement_noise;
    logic signed [31:0] last_estimate;
    logic [31:0]        error_variance;
    logic signed [31:0] expected_estimates[$];
    int                 failures;

    function new();
        process_noise     = skf_pkg::PROCESS_NOISE_RST;
        measurement_noise = skf_pkg::MEASUREMENT_NOISE_RST;
        last_estimate     = '0;
        error_variance    = '0;
        failures          = 0;
    endfunction

    function void write_reg(logic [skf_pkg::CFG_INDEX_W-1:0] index, logic [31:0] value);
        if (index == skf_pkg::REG_PROCESS_NOISE)
            process_noise = value;
        else if (index == skf_pkg::REG_MEASUREMENT_NOISE)
            measurement_noise = value;
    endfunction

    // Advance the filter by one sample and queue the estimate it must produce
    function void note_sample(logic signed [31:0] z);
        logic [63:0] pm;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] mag;
        logic [63:0] step;
        logic [63:0] one;
        logic [63:0] half;
        longint      zl;
        longint      xl;
        logic [63:0] next_x;
        bit          up;
        one  = 64'd1 << skf_pkg::FRAC_BITS;
        half = 64'(skf_pkg::HALF_Q24);
        pm = 64'(error_variance) + 64'(process_noise);
        if (pm > 64'(skf_pkg::VAR_MAX))
            pm = 64'(skf_pkg::VAR_MAX);
        den = pm + 64'(measurement_noise);
        if (den == 64'd0)
            gain = 64'd0;
        else
            gain = ((pm << skf_pkg::FRAC_BITS) + (den >> 1)) / den;
        if (gain > one)
            gain = one;
        zl = z;
        xl = last_estimate;
        up = (z >= last_estimate);
        mag = up ? 64'(zl - xl) : 64'(xl - zl);
        // round half up on the magnitude, i.e. away from zero toward the sample
        step = (mag * gain + half) >> skf_pkg::FRAC_BITS;
        next_x = up ? 64'(xl) + step : 64'(xl) - step;
        last_estimate = next_x[31:0];
        error_variance = 32'((((one - gain) * pm) + half) >> skf_pkg::FRAC_BITS);
        expected_estimates.push_back(next_x[31:0]);
    endfunction

    function void check_estimate(logic signed [31:0] actual);
        logic signed [31:0] want;
        if (expected_estimates.size() == 0)
        begin
            $error("estimate: expected none pending, actual %0d", actual);
            failures++;
            return;
        end
        want = expected_estimates.pop_front();
        if (actual !== want)
        begin
            $error("estimate: expected %0d, actual %0d", want, actual);
            failures++;
        end
    endfunction
endclass

module tb_top;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [skf_pkg::CFG_INDEX_W-1:0]   cfg_index = skf_pkg::REG_PROCESS_NOISE;
    logic [skf_pkg::VAR_W-1:0]         cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic signed [31:0]                sample    = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [31:0]                estimate;

    logic                              in_fire_q = 1'b0;
    int                                sender_idle_pct = 29;
    int                                receiver_idle_pct = 45;

    estimate_tracker tracker = new();

    scalar_kalman_smoother_top #(.SAMPLE_WIDTH(32)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .estimate  (estimate)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire_q <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                tracker.note_sample(sample);
            if (out_valid && !out_stall)
                tracker.check_estimate(estimate);
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_idle_pct);

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_sample(input logic signed [31:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            sample   <= $urandom;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(negedge clk);
        while (!in_fire_q);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.expected_estimates.size() != 0)
            @(negedge clk);
        // let the sequencer settle before touching the registers
        repeat (40) @(negedge clk);
    endtask

    task automatic apply_noise(input logic [31:0] q, input logic [31:0] r);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= skf_pkg::REG_PROCESS_NOISE;
        cfg_data  <= q;
        tracker.write_reg(skf_pkg::REG_PROCESS_NOISE, q);
        @(negedge clk);
        cfg_index <= skf_pkg::REG_MEASUREMENT_NOISE;
        cfg_data  <= r;
        tracker.write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return skf_pkg::VAR_MAX;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0200_0000);
        endcase
    endfunction

    // Half of the picks are a slow walk around the current estimate, like a measured angle
    function automatic logic signed [31:0] pick_sample(input logic signed [31:0] near);
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return $urandom;
            default: return near + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of Q and R
        send_sample(32'sh0000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'shFFFF_FFFF);
        send_sample(32'sh0000_0001);
        send_sample(32'sh0001_0000);
        send_sample(32'shFFFF_0000);

        // no noise: full gain once, then a zero gain denominator holds the estimate
        apply_noise(32'd0, 32'd0);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh1234_5678);

        // saturate the predicted variance
        apply_noise(skf_pkg::VAR_MAX, skf_pkg::VAR_MAX);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0000_0000);
        send_sample(32'sh5555_5555);

        apply_noise(skf_pkg::VAR_MAX, 32'd0);
        send_sample(32'sh0000_0000);
        send_sample(32'sh7FFF_FFFF);

        apply_noise(32'd0, skf_pkg::VAR_MAX);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);

        for (int ph = 0; ph < 9; ph++)
        begin
            sender_idle_pct   = (ph < 3) ? 29 : (ph < 6) ? 45 : 0;
            receiver_idle_pct = (ph < 3) ? 45 : (ph < 6) ? 29 : 0;
            apply_noise(pick_noise(), pick_noise());
            repeat (190) send_sample(pick_sample(tracker.last_estimate));
        end

        drain_results();
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
sv/skf_pkg.sv
sv/scalar_kalman_smoother_top.sv
verif/tb_top.sv
